/* sv/psc_pkg.sv */
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants for the prism sub-element connectivity block.
// ----------------------------------------------------------------------------
package psc_pkg;

   localparam int unsigned MAX_DEGREE = 8;
   localparam int unsigned DEG_W      = 4;
   localparam int unsigned LAYER_W    = 3;
   localparam int unsigned NODE_W     = 9;
   localparam int unsigned TRI_W      = 6;
   localparam int unsigned IDX_W      = 3;

   typedef logic [DEG_W-1:0]   degree_type;
   typedef logic [LAYER_W-1:0] layer_type;
   typedef logic [NODE_W-1:0]  node_type;
   typedef logic [TRI_W-1:0]   tri_type;
   typedef logic [IDX_W-1:0]   idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_BAD
   } state_type;

   typedef struct packed {
      logic load_req;
      logic step;
      logic emit_bad;
   } cmd_type;

   typedef struct packed {
      logic bad_req;
      logic out_free;
      logic last_item;
   } stat_type;

   // triangle node count (p+1)(p+2)/2
   function automatic tri_type tri_count(degree_type p);
      tri_type t;
      case (p)
         4'd0:    t = 6'd1;
         4'd1:    t = 6'd3;
         4'd2:    t = 6'd6;
         4'd3:    t = 6'd10;
         4'd4:    t = 6'd15;
         4'd5:    t = 6'd21;
         4'd6:    t = 6'd28;
         4'd7:    t = 6'd36;
         4'd8:    t = 6'd45;
         default: t = 6'd45;
      endcase
      return t;
   endfunction

endpackage

/* sv/psc_if.sv */
// ----------------------------------------------------------------------------
// psc_req_if / psc_rsp_if
// Valid/ready channels for layer requests and sub-prism results.
// ----------------------------------------------------------------------------
interface psc_req_if;
   import psc_pkg::*;
   logic      valid;
   logic      ready;
   layer_type layer;

   modport source (output valid, output layer, input ready);
   modport sink   (input valid, input layer, output ready);
endinterface

interface psc_rsp_if;
   import psc_pkg::*;
   logic     valid;
   logic     ready;
   node_type node_a;
   node_type node_b;
   node_type node_c;
   node_type node_d;
   node_type node_e;
   node_type node_f;
   logic     last;
   logic     bad_layer;

   modport source (output valid, output node_a, output node_b, output node_c,
                   output node_d, output node_e, output node_f, output last,
                   output bad_layer, input ready);
   modport sink   (input valid, input node_a, input node_b, input node_c,
                   input node_d, input node_e, input node_f, input last,
                   input bad_layer, output ready);
endinterface

/* sv/psc_ctrl.sv */
// ----------------------------------------------------------------------------
// psc_ctrl
// Sequencer: accepts a request, then commands the datapath once per result.
// ----------------------------------------------------------------------------
module psc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  psc_pkg::stat_type  stat,
   output psc_pkg::cmd_type   cmd
);
   import psc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.bad_req ? ST_BAD : ST_RUN;
            end
         end
         ST_RUN: begin
            if (stat.out_free && stat.last_item) begin
               state_in = ST_IDLE;
            end
         end
         ST_BAD: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.load_req = 1'b0;
      cmd.step     = 1'b0;
      cmd.emit_bad = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_RUN:  cmd.step     = stat.out_free;
         ST_BAD:  cmd.emit_bad = stat.out_free;
         default: req_ready    = 1'b0;
      endcase
   end

endmodule

/* sv/psc_dp.sv */
// ----------------------------------------------------------------------------
// psc_dp
// Row/column walk over one layer, node arithmetic and the result register.
// ----------------------------------------------------------------------------
module psc_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  psc_pkg::degree_type   csr_wdata,
   input  psc_pkg::layer_type    req_layer,
   input  psc_pkg::cmd_type      cmd,
   output psc_pkg::stat_type     stat,
   psc_rsp_if.source             rsp
);
   import psc_pkg::*;

   degree_type degree_ff;
   degree_type deg_eff;
   tri_type    tri_ff;
   node_type   start_ff, start_in;
   node_type   prev_ff, prev_in;
   idx_type    row_ff, row_in;
   idx_type    col_ff, col_in;
   logic       down_ff, down_in;

   logic       valid_ff;
   node_type   na_ff, nb_ff, nc_ff, nd_ff, ne_ff, nf_ff;
   logic       last_ff, bad_ff;

   degree_type rem;
   logic       col_last;
   logic       row_last;
   node_type   next_row;
   node_type   na, nb, nc;
   node_type   tri_ext;

   assign deg_eff  = (degree_ff > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_ff;
   assign rem      = deg_eff - {1'b0, row_ff} - 4'd1;
   assign col_last = ({1'b0, col_ff} == rem);
   assign row_last = ({1'b0, row_ff} == (deg_eff - 4'd1));
   assign next_row = start_ff + NODE_W'(deg_eff) + 9'd1 - NODE_W'(row_ff);
   assign tri_ext  = NODE_W'(tri_ff);

   assign na = start_ff + NODE_W'(col_ff);
   assign nb = down_ff ? (prev_ff + 9'd1 + NODE_W'(col_ff)) : (na + 9'd1);
   assign nc = down_ff ? (na + 9'd1) : (next_row + NODE_W'(col_ff));

   assign stat.bad_req   = ({1'b0, req_layer} >= deg_eff);
   assign stat.out_free  = !valid_ff || rsp.ready;
   assign stat.last_item = !down_ff && col_last && row_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= 4'd1;
      end else if (csr_we) begin
         degree_ff <= csr_wdata;
      end
   end

   always_comb begin
      start_in = start_ff;
      prev_in  = prev_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      down_in  = down_ff;
      if (cmd.load_req) begin
         start_in = NODE_W'(req_layer) * NODE_W'(tri_count(deg_eff));
         prev_in  = NODE_W'(req_layer) * NODE_W'(tri_count(deg_eff));
         row_in   = '0;
         col_in   = '0;
         down_in  = 1'b0;
      end else if (cmd.step) begin
         if (!col_last) begin
            col_in = col_ff + 3'd1;
         end else if (down_ff) begin
            col_in  = '0;
            down_in = 1'b0;
         end else begin
            col_in   = '0;
            down_in  = 1'b1;
            row_in   = row_ff + 3'd1;
            prev_in  = start_ff;
            start_in = next_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      prev_ff  <= prev_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      down_ff  <= down_in;
      if (cmd.load_req) begin
         tri_ff <= tri_count(deg_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.step || cmd.emit_bad) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_bad) begin
         na_ff   <= '0;
         nb_ff   <= '0;
         nc_ff   <= '0;
         nd_ff   <= '0;
         ne_ff   <= '0;
         nf_ff   <= '0;
         last_ff <= 1'b1;
         bad_ff  <= 1'b1;
      end else if (cmd.step) begin
         na_ff   <= na;
         nb_ff   <= nb;
         nc_ff   <= nc;
         nd_ff   <= na + tri_ext;
         ne_ff   <= nb + tri_ext;
         nf_ff   <= nc + tri_ext;
         last_ff <= stat.last_item;
         bad_ff  <= 1'b0;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.node_a    = na_ff;
   assign rsp.node_b    = nb_ff;
   assign rsp.node_c    = nc_ff;
   assign rsp.node_d    = nd_ff;
   assign rsp.node_e    = ne_ff;
   assign rsp.node_f    = nf_ff;
   assign rsp.last      = last_ff;
   assign rsp.bad_layer = bad_ff;

endmodule

/* sv/prism_subelement_connectivity.sv */
// ----------------------------------------------------------------------------
// prism_subelement_connectivity
// Emits the six node indices of every linear sub-prism in one prism layer.
// ----------------------------------------------------------------------------
// One request is handled at a time. A valid layer at degree p is accepted
// and then delivers p*p results, one per cycle while the result side keeps
// up, set by the single row/column walk in the datapath; a rejected layer
// is accepted and then registers its single result, flagged bad, once the
// result side is free. The effective degree saturates at 8; the degree register
// is to be written only while idle, by the user; the block itself does not enforce this.
module prism_subelement_connectivity (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  psc_pkg::degree_type  csr_wdata,
   psc_req_if.sink              req_chan,
   psc_rsp_if.source            rsp_chan
);
   import psc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   psc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   psc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_layer (req_chan.layer),
      .cmd       (cmd),
      .stat      (stat),
      .rsp       (rsp_chan)
   );

endmodule

/* dv/psc_checker.sv */
// ----------------------------------------------------------------------------
// psc_checker
// Watches the request, result and register ports of the prism sub-element
// connectivity block, predicts the sub-prisms of each accepted layer request
// and compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module psc_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  psc_pkg::degree_type csr_wdata,
   psc_req_if                  req_mon,
   psc_rsp_if                  rsp_mon,
   output int                  mismatches,
   output int                  outstanding,
   output int                  results_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import psc_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      node_type a;
      node_type b;
      node_type c;
      node_type d;
      node_type e;
      node_type f;
      logic     last;
      logic     bad;
   } sub_prism_type;

   sub_prism_type expected_prisms[$];
   degree_type    degree_reg;
   int            err_count;
   int            seen_count;
   sub_prism_type got;
   sub_prism_type want;

   function automatic sub_prism_type make_prism(int a, int b, int c, int tri_n);
      sub_prism_type s;
      s.a    = node_type'(a);
      s.b    = node_type'(b);
      s.c    = node_type'(c);
      s.d    = node_type'(a + tri_n);
      s.e    = node_type'(b + tri_n);
      s.f    = node_type'(c + tri_n);
      s.last = 1'b0;
      s.bad  = 1'b0;
      return s;
   endfunction

   function automatic void enqueue_prism(sub_prism_type s);
      expected_prisms.insert(expected_prisms.size(), s);
   endfunction

   // queue every sub-prism of one layer, downward ones of a row before upward; one bad entry if rejected
   function automatic void predict_layer(degree_type deg, layer_type lyr);
      int            p;
      int            tri_n;
      int            row_start;
      int            row_prev;
      int            row_next;
      sub_prism_type rej;
      p = (deg > MAX_DEGREE) ? MAX_DEGREE : int'(deg);
      if (int'(lyr) >= p) begin
         rej      = '0;
         rej.last = 1'b1;
         rej.bad  = 1'b1;
         enqueue_prism(rej);
         return;
      end
      tri_n     = (p + 1) * (p + 2) / 2;
      row_start = int'(lyr) * tri_n;
      row_prev  = row_start;
      for (int j = 0; j < p; j++) begin
         if (j > 0) begin
            for (int i = 0; i < p - j; i++) begin
               enqueue_prism(make_prism(row_start + i, row_prev + 1 + i,
                                        row_start + i + 1, tri_n));
            end
         end
         row_next = row_start + p + 1 - j;
         for (int i = 0; i < p - j; i++) begin
            enqueue_prism(make_prism(row_start + i, row_start + i + 1,
                                     row_next + i, tri_n));
         end
         row_prev  = row_start;
         row_start = row_next;
      end
      expected_prisms[expected_prisms.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         degree_reg = 4'd1;
         expected_prisms.delete();
         err_count  = 0;
         seen_count = 0;
      end else begin
         if (csr_we)
            degree_reg = csr_wdata;
         if (req_mon.valid && req_mon.ready)
            predict_layer(degree_reg, req_mon.layer);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.a    = rsp_mon.node_a;
            got.b    = rsp_mon.node_b;
            got.c    = rsp_mon.node_c;
            got.d    = rsp_mon.node_d;
            got.e    = rsp_mon.node_e;
            got.f    = rsp_mon.node_f;
            got.last = rsp_mon.last;
            got.bad  = rsp_mon.bad_layer;
            seen_count++;
            if (expected_prisms.size() == 0) begin
               err_count++;
               if (err_count <= MAX_REPORTS)
                  $display({"[%0t] unexpected result transfer: a=%0d b=%0d c=%0d",
                            " d=%0d e=%0d f=%0d last=%0b bad=%0b"},
                           $time, got.a, got.b, got.c, got.d, got.e, got.f,
                           got.last, got.bad);
            end else begin
               want = expected_prisms.pop_front();
               if (got !== want) begin
                  err_count++;
                  if (err_count <= MAX_REPORTS) begin
                     $display("[%0t] result mismatch", $time);
                     $display("   exp a=%0d b=%0d c=%0d d=%0d e=%0d f=%0d last=%0b bad=%0b",
                              want.a, want.b, want.c, want.d, want.e, want.f,
                              want.last, want.bad);
                     $display("   got a=%0d b=%0d c=%0d d=%0d e=%0d f=%0d last=%0b bad=%0b",
                              got.a, got.b, got.c, got.d, got.e, got.f,
                              got.last, got.bad);
                  end
               end
            end
         end
      end
      mismatches      <= err_count;
      outstanding     <= expected_prisms.size();
      results_checked <= seen_count;
   end

endmodule

/* dv/prism_subelement_connectivity_tb.sv */
// ----------------------------------------------------------------------------
// prism_subelement_connectivity_tb
// Drives layer requests and degree settings into the prism sub-element
// connectivity block under varying idle and stall mixes; the checker beside
// the block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module prism_subelement_connectivity_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import psc_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;

   logic       clock;
   logic       reset;
   logic       csr_we;
   degree_type csr_wdata;
   degree_type cur_degree;
   int         send_idle_pct;
   int         recv_stall_pct;
   int         hold_left;
   int         items_sent;
   int         cycle_count;
   int         errors;
   int         pending;
   int         checked;

   psc_req_if req_chan ();
   psc_rsp_if rsp_chan ();

   prism_subelement_connectivity DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   psc_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .mismatches      (errors),
      .outstanding     (pending),
      .results_checked (checked)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic offer_layer(input layer_type lyr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.layer <= lyr;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_degree(input degree_type value);
      wait_drain();
      csr_we     <= 1'b1;
      csr_wdata  <= value;
      cur_degree = value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic layer_type pick_layer();
      int p;
      p = (cur_degree > MAX_DEGREE) ? MAX_DEGREE : int'(cur_degree);
      if (p == 0 || $urandom_range(99) < 15)
         return layer_type'($urandom_range(7));
      return layer_type'($urandom_range(p - 1));
   endfunction

   function automatic degree_type pick_degree();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return degree_type'($urandom_range(4, 1));
      if (r < 75)
         return degree_type'($urandom_range(8, 5));
      return degree_type'($urandom_range(15));
   endfunction

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      cur_degree     = 4'd1;
      req_chan.valid = 1'b0;
      req_chan.layer = '0;
      rsp_chan.ready = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 0;
      items_sent     = 0;
      cycle_count    = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset degree, zero degree, top degree, saturation, boundaries
      offer_layer(3'd0);
      offer_layer(3'd1);
      offer_layer(3'd7);
      write_degree(4'd0);
      offer_layer(3'd0);
      offer_layer(3'd7);
      write_degree(4'd8);
      offer_layer(3'd0);
      offer_layer(3'd7);
      offer_layer(3'd3);
      write_degree(4'd15);
      offer_layer(3'd7);
      offer_layer(3'd0);
      write_degree(4'd4);
      offer_layer(3'd3);
      offer_layer(3'd4);
      write_degree(4'd9);
      offer_layer(3'd5);

      // long result-side hold while requests keep coming
      write_degree(4'd8);
      hold_left = 400;
      for (int n = 0; n < 5; n++)
         offer_layer(pick_layer());
      wait_drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         for (int s = 0; s < 6; s++) begin
            write_degree(pick_degree());
            for (int n = 0; n < 20; n++) begin
               offer_layer(pick_layer());
               if (n == 10 && s == 2)
                  wait_drain();
            end
         end
      end

      wait_drain();
      repeat (20) @(posedge clock);

      $display("Covered %0d layer requests over degrees 0 to 15, with rejected layers,",
               items_sent);
      $display("saturated degrees, long hold-offs and four idle/stall mixes; %0d results checked.",
               checked);
      if (errors == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
